// ----- rtl/core/hha_pkg.sv -----
// Shared constants, codes and controller/datapath handshake structs for the
// hashed handle allocator. No dependencies; imported by every module of the block.

package hha_pkg;

    // Table geometry and field widths
    localparam int SLOTS    = 256;
    localparam int CTX_BITS = 32;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int HANDLE_W = 24;
    localparam int CTX_W    = 32;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int NH_W     = HANDLE_W + 1;
    localparam int TDATA_W  = ((HANDLE_W + CTX_W + 7) / 8) * 8;

    localparam logic [HANDLE_W-1:0] HANDLE_LIMIT = '1;

    // Operation codes carried on the slave tuser
    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_RETIRE   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;

    // Status codes carried on the master tuser
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the accepted transaction, start the table read
        logic check;     // compare the read entry for retire and lookup
        logic probe;     // test one slot for a register request
        logic out_load;  // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_reg;      // incoming transaction is a register request
        logic probe_done;  // empty slot found or last slot probed
        logic out_free;    // output register can take a result this cycle
    } t_sts;

endpackage

// ----- rtl/core/hashed_handle_allocator.sv -----
// Top level of the hashed handle allocator: joins the controller and the
// datapath. Depends on hha_pkg, hha_ctrl and hha_dpath.
//
// The block maps 24-bit handles to context references in a 256-slot table.
// Requests arrive on the slave stream: tuser carries the operation (register,
// retire, look up), tdata carries the handle and the context. Each request
// produces exactly one result transaction on the master stream: tuser carries
// the status, tdata the handle and the context found.
// Requests are processed one at a time. A retire or lookup reads the slot
// memory once at acceptance and compares the entry in the check state. A
// register request walks the valid bits one slot per cycle starting at the
// running handle counter, probing from 1 slot (when the next slot is free)
// up to 256 slots (when the table is full). Either result then waits in the
// done state until the output register can take it.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits; a stalled receiver only holds the block
// when a second result is ready and the output register is still occupied.
// Reset (synchronous, active low) empties every slot at once through the
// valid bits, sets the handle counter to 1 and drops the output valid. The
// slot memories are not cleared; an entry is only read behind its valid bit.

module hashed_handle_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: handle_in [23:0], context_in [55:24]
    input  logic [hha_pkg::TDATA_W-1:0]     s_axis_tdata,
    // tuser: opcode [1:0]
    input  logic [hha_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: handle_out [23:0], context_out [55:24]
    output logic [hha_pkg::TDATA_W-1:0]     m_axis_tdata,
    // tuser: status [1:0]
    output logic [hha_pkg::ST_W-1:0]        m_axis_tuser
);
    import hha_pkg::*;

    t_cmd cmd;
    t_sts sts;

    hha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hha_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

    // Only one request is in flight: acceptance is never followed by another
    // acceptance in the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // A successful result never carries the reserved handle zero.
    a_no_zero_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_OK) |-> m_axis_tdata[HANDLE_W-1:0] != '0)
        else $error("reserved handle zero reported on success");

    // Failures report neither a handle nor a context.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
        else $error("failed transaction carries nonzero payload");

    // Only defined status codes are produced.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_ABSENT)
                          || (m_axis_tuser == ST_FULL))
        else $error("undefined status code");

endmodule

// ----- rtl/core/hha_ctrl.sv -----
// Sequencing state machine of the hashed handle allocator.
// Depends on hha_pkg for the command and status structs.

module hha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  hha_pkg::t_sts i_sts,
    output hha_pkg::t_cmd o_cmd
);
    import hha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_PROBE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.is_reg ? S_PROBE : S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_DONE;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_sts.probe_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/hha_dpath.sv -----
// Datapath of the hashed handle allocator: slot memories, valid bits, handle
// counter, probe logic and the output register. Depends on hha_pkg.

module hha_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hha_pkg::t_cmd                   i_cmd,
    output hha_pkg::t_sts                   o_sts,
    input  logic [hha_pkg::TDATA_W-1:0]     i_s_tdata,
    input  logic [hha_pkg::OP_W-1:0]        i_s_tuser,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [hha_pkg::TDATA_W-1:0]     o_m_tdata,
    output logic [hha_pkg::ST_W-1:0]        o_m_tuser
);
    import hha_pkg::*;

    // Slot storage; contents are only meaningful while the valid bit is set.
    logic [HANDLE_W-1:0] r_mem_handle [SLOTS];
    logic [CTX_BITS-1:0] r_mem_ctx    [SLOTS];
    logic [SLOTS-1:0]    r_valid;

    logic [NH_W-1:0]     r_next_handle;
    logic [NH_W-1:0]     r_probe_h;
    logic [SLOT_W-1:0]   r_cnt;

    logic [OP_W-1:0]     r_op;
    logic [HANDLE_W-1:0] r_hin;
    logic [CTX_BITS-1:0] r_ctx;
    logic [HANDLE_W-1:0] r_rd_handle;
    logic [CTX_BITS-1:0] r_rd_ctx;

    logic [ST_W-1:0]     r_res_status;
    logic [HANDLE_W-1:0] r_res_handle;
    logic [CTX_W-1:0]    r_res_ctx;

    logic                r_out_valid;
    logic [ST_W-1:0]     r_out_status;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [CTX_W-1:0]    r_out_ctx;

    logic [HANDLE_W-1:0] in_handle;
    logic [SLOT_W-1:0]   in_idx;
    logic [SLOT_W-1:0]   chk_idx;
    logic                hit;
    logic [NH_W-1:0]     probe_h;
    logic [SLOT_W-1:0]   probe_idx;
    logic                probe_empty;
    logic                probe_last;

    assign in_handle = i_s_tdata[HANDLE_W-1:0];
    assign in_idx    = in_handle[SLOT_W-1:0];
    assign chk_idx   = r_hin[SLOT_W-1:0];

    assign hit = ((r_op == OP_RETIRE) || (r_op == OP_LOOKUP))
                 && r_valid[chk_idx] && (r_rd_handle == r_hin);

    // Handle zero is reserved, so the counter skips from the limit back to one.
    assign probe_h     = (r_probe_h > {1'b0, HANDLE_LIMIT}) ? NH_W'(1) : r_probe_h;
    assign probe_idx   = probe_h[SLOT_W-1:0];
    assign probe_empty = !r_valid[probe_idx];
    assign probe_last  = (r_cnt == '1);

    assign o_sts.is_reg     = (i_s_tuser == OP_REGISTER);
    assign o_sts.probe_done = probe_empty || probe_last;
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    // Memory write on a successful probe; registered read at acceptance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe && probe_empty) begin
            r_mem_handle[probe_idx] <= probe_h[HANDLE_W-1:0];
            r_mem_ctx[probe_idx]    <= r_ctx;
        end
        if (i_cmd.load) begin
            r_rd_handle <= r_mem_handle[in_idx];
            r_rd_ctx    <= r_mem_ctx[in_idx];
        end
    end

    // Control state: valid bits, handle counter, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_next_handle <= NH_W'(1);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.check && hit && (r_op == OP_RETIRE)) begin
                r_valid[chk_idx] <= 1'b0;
            end
            if (i_cmd.probe && probe_empty) begin
                r_valid[probe_idx] <= 1'b1;
                r_next_handle      <= probe_h + NH_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction capture, probe walk and result formation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_s_tuser;
            r_hin     <= in_handle;
            r_ctx     <= CTX_BITS'(i_s_tdata[HANDLE_W +: CTX_W]);
            r_probe_h <= r_next_handle;
            r_cnt     <= '0;
        end
        if (i_cmd.check) begin
            r_res_status <= hit ? ST_OK : ST_ABSENT;
            r_res_handle <= hit ? r_hin : '0;
            r_res_ctx    <= (hit && (r_op == OP_LOOKUP)) ? CTX_W'(r_rd_ctx) : '0;
        end
        if (i_cmd.probe) begin
            r_probe_h <= probe_h + NH_W'(1);
            r_cnt     <= r_cnt + SLOT_W'(1);
            if (probe_empty) begin
                r_res_status <= ST_OK;
                r_res_handle <= probe_h[HANDLE_W-1:0];
                r_res_ctx    <= '0;
            end else if (probe_last) begin
                r_res_status <= ST_FULL;
                r_res_handle <= '0;
                r_res_ctx    <= '0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_handle <= r_res_handle;
            r_out_ctx    <= r_res_ctx;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = TDATA_W'({r_out_ctx, r_out_handle});

endmodule

// ----- sim/hashed_handle_allocator_test.sv -----
// Self-checking testbench for the hashed handle allocator: directed and random
// register, retire and lookup transactions checked against a behavioral table model.
// Depends on hha_pkg and the hashed_handle_allocator top level.

module hashed_handle_allocator_test;
    import hha_pkg::*;

    // The opcode space has one unused code; the block must answer it as absent.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles without any transaction on either stream before the run is abandoned.
    // The slowest legal gap is a register request against a full table, which probes every slot.
    localparam int STUCK_LIMIT = 4000;

    // Number of random transactions in each idling phase.
    localparam int PHASE_ITEMS = 160;

    // One result as it travels on the master stream.
    typedef struct packed {
        logic [ST_W-1:0]     status;
        logic [HANDLE_W-1:0] handle;
        logic [CTX_W-1:0]    ctx;
    } t_table_answer;

    // Behavioral copy of the handle table. Each accepted request updates the
    // copy and queues the answer the block must give for it; each result taken
    // from the block is compared with the oldest queued answer.
    class handle_table_model;
        bit                  slot_valid   [SLOTS];
        logic [HANDLE_W-1:0] slot_handle  [SLOTS];
        logic [CTX_W-1:0]    slot_context [SLOTS];
        logic [NH_W-1:0]     next_handle;
        t_table_answer       awaited_answers [$];
        int                  errors;

        function new();
            foreach (slot_valid[i]) begin
                slot_valid[i]   = 1'b0;
                slot_handle[i]  = '0;
                slot_context[i] = '0;
            end
            next_handle = 1;
            errors      = 0;
        endfunction

        // Apply one accepted request to the table and queue its answer.
        function void note_request(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                   logic [CTX_W-1:0] c);
            t_table_answer     ans;
            logic [NH_W-1:0]   probe;
            logic [SLOT_W-1:0] idx;
            bit                hit;
            idx = h[SLOT_W-1:0];
            hit = slot_valid[idx] && (slot_handle[idx] == h);
            ans = '{status: ST_ABSENT, handle: '0, ctx: '0};
            case (op)
                OP_REGISTER: begin
                    // Walk successive handles from the counter; the counter skips
                    // handle zero when it runs past the top of the handle space.
                    ans.status = ST_FULL;
                    probe = next_handle;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (probe > NH_W'(HANDLE_LIMIT)) probe = 1;
                        idx = probe[SLOT_W-1:0];
                        if (!slot_valid[idx]) begin
                            slot_valid[idx]   = 1'b1;
                            slot_handle[idx]  = probe[HANDLE_W-1:0];
                            slot_context[idx] = c;
                            next_handle       = probe + 1'b1;
                            ans.status        = ST_OK;
                            ans.handle        = probe[HANDLE_W-1:0];
                            break;
                        end
                        probe = probe + 1'b1;
                    end
                end
                OP_RETIRE: begin
                    if (hit) begin
                        slot_valid[idx] = 1'b0;
                        ans.status      = ST_OK;
                        ans.handle      = h;
                    end
                end
                OP_LOOKUP: begin
                    if (hit) begin
                        ans.status = ST_OK;
                        ans.handle = h;
                        ans.ctx    = slot_context[idx];
                    end
                end
                default: ;
            endcase
            awaited_answers.push_back(ans);
        endfunction

        // Compare one result from the block with the oldest queued answer.
        function void check_result(logic [ST_W-1:0] st, logic [HANDLE_W-1:0] h,
                                   logic [CTX_W-1:0] c);
            t_table_answer want;
            if (awaited_answers.size() == 0) begin
                errors++;
                $display("%0t: result with nothing awaited: status %0d handle %h context %h",
                         $time, st, h, c);
                return;
            end
            want = awaited_answers.pop_front();
            if (st !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
            if (h !== want.handle) begin
                errors++;
                $display("%0t: handle expected %h actual %h", $time, want.handle, h);
            end
            if (c !== want.ctx) begin
                errors++;
                $display("%0t: context expected %h actual %h", $time, want.ctx, c);
            end
        endfunction

        // A handle currently held in the table, or a random one when the few
        // slots tried happen to be empty.
        function logic [HANDLE_W-1:0] live_handle();
            int idx;
            for (int i = 0; i < 16; i++) begin
                idx = $urandom_range(SLOTS - 1);
                if (slot_valid[idx]) return slot_handle[idx];
            end
            return HANDLE_W'($urandom());
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;   // handle_in [23:0], context_in [55:24]
    logic [OP_W-1:0]      s_axis_tuser;   // opcode [1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;   // handle_out [23:0], context_out [55:24]
    logic [ST_W-1:0]      m_axis_tuser;   // status [1:0]

    handle_table_model alloc_model;

    // Idling percentages of the current phase, read by the driver and the sink.
    int src_idle_pct;
    int sink_stall_pct;
    int stuck_cycles = 0;

    hashed_handle_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result sink and watchdog. Both stream groups are sampled just after the
    // rising edge, before any register of the block or the testbench updates,
    // so each sample shows the values the block saw at that edge. The sink
    // drops tready at random to hold results back in the output register.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            alloc_model.check_result(m_axis_tuser, m_axis_tdata[HANDLE_W-1:0],
                                     m_axis_tdata[HANDLE_W +: CTX_W]);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("hashed_handle_allocator verification failed");
            $finish;
        end
    end

    // Offer one request on the slave stream, with a random number of idle
    // cycles in front, and return once the transaction has been accepted. The
    // model is updated at acceptance, which keeps it in step with the block.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                                input logic [CTX_W-1:0] c);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {c, h};
        do @(posedge i_clk); while (!s_axis_tready);
        alloc_model.note_request(op, h, c);
    endtask

    // Context values lean on the extremes now and then.
    function automatic logic [CTX_W-1:0] pick_context();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return CTX_W'($urandom());
        endcase
    endfunction

    // One random request. Most traffic is registers plus retires and lookups
    // of handles the table really holds, so the probe walk, hits and frees
    // all get exercised; the rest aims at same-slot aliases, stray handles,
    // handle zero, the top handle and the unused opcode.
    task automatic random_request(input int reg_pct);
        logic [HANDLE_W-1:0] h;
        logic [OP_W-1:0]     op;
        op = ($urandom_range(1)) ? OP_RETIRE : OP_LOOKUP;
        if ($urandom_range(99) < reg_pct) begin
            send_request(OP_REGISTER, HANDLE_W'($urandom()), pick_context());
        end else begin
            case ($urandom_range(9))
                0, 1, 2: send_request(OP_LOOKUP, alloc_model.live_handle(), pick_context());
                3, 4, 5: send_request(OP_RETIRE, alloc_model.live_handle(), pick_context());
                6: begin
                    // Same slot as a live entry, different handle: must miss.
                    h = alloc_model.live_handle() + (HANDLE_W'($urandom_range(1, 255)) << SLOT_W);
                    send_request(op, h, pick_context());
                end
                7: send_request(op, HANDLE_W'($urandom()), pick_context());
                8: send_request(OP_UNUSED, HANDLE_W'($urandom()), pick_context());
                default: send_request(op, ($urandom_range(1)) ? HANDLE_LIMIT : '0,
                                      pick_context());
            endcase
        end
    endtask

    initial begin
        alloc_model    = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_REGISTER;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An empty table answers absent for handle zero, the top
        // handle and the unused opcode, whatever the other fields hold.
        send_request(OP_LOOKUP, '0, '1);
        send_request(OP_RETIRE, '0, '0);
        send_request(OP_UNUSED, HANDLE_LIMIT, '1);
        send_request(OP_LOOKUP, HANDLE_LIMIT, '0);
        // The first registers take handles 1, 2, 3; handle_in is ignored.
        send_request(OP_REGISTER, '0, '0);
        send_request(OP_REGISTER, HANDLE_LIMIT, '1);
        send_request(OP_REGISTER, 24'h5A5A5A, 32'hA5A5_A5A5);
        send_request(OP_LOOKUP, 24'd1, '1);
        send_request(OP_LOOKUP, 24'd2, '0);
        // Handle 258 shares slot 2 with handle 2 but is not stored there.
        send_request(OP_LOOKUP, 24'd2 + SLOTS, '0);
        send_request(OP_RETIRE, 24'd2 + SLOTS, '0);
        send_request(OP_RETIRE, 24'd2, '0);
        send_request(OP_LOOKUP, 24'd2, '0);
        send_request(OP_RETIRE, 24'd2, '0);
        send_request(OP_RETIRE, HANDLE_LIMIT, '1);
        // The unused opcode must leave handle 1 in place.
        send_request(OP_UNUSED, 24'd1, '0);
        send_request(OP_LOOKUP, 24'd1, '0);
        // The counter has moved past the freed slot 2, so this takes handle 4.
        send_request(OP_REGISTER, '0, 32'h8000_0001);
        send_request(OP_LOOKUP, 24'd3, '0);
        send_request(OP_LOOKUP, 24'd4, '0);

        // Random part in four idling phases. The first two are register-heavy
        // so the table fills and later registers report it full; the third
        // drains it and the last one mixes everything.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case (phase)
                    0, 1:    random_request(95);
                    2:       random_request(20);
                    default: random_request(50);
                endcase
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding results, then give the block a few more cycles
        // to show any stray result it should not produce.
        while (alloc_model.awaited_answers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (alloc_model.errors == 0 && alloc_model.awaited_answers.size() == 0) begin
            $display("hashed_handle_allocator verification clean");
        end else begin
            $display("hashed_handle_allocator verification failed");
        end
        $finish;
    end

endmodule
